@@ rtl/rolling_xor_key_stream_cipher_defines.svh @@
// Assertion macros for the checker file of the rolling XOR cipher.
`ifndef ROLLING_XOR_KEY_STREAM_CIPHER_DEFINES_SVH
`define ROLLING_XOR_KEY_STREAM_CIPHER_DEFINES_SVH

// Plain property, sampled on the rising clock, off while reset is active.
`define RXK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define RXK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rxk_pkg.sv @@
// Shared types, constants and helpers of the rolling XOR key stream cipher.
`timescale 1ns / 1ps

package rxk_pkg;

    localparam int KEY_TEXT_DEPTH_DEF = 1024;

    localparam logic [7:0] CH_SUBST     = 8'h2E;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_ASCII_MAX = 8'd127;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_DATA  = 2'd2
    } cmd_t;

    // Text store control for one cycle
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    // Decoded request strobes for the key unit
    typedef struct packed {
        logic start;
        logic data;
    } item_ctl_t;

    // Map characters above ASCII and the percent sign to a period
    function automatic logic [7:0] clean_char(input logic [7:0] c);
        if ((c > CH_ASCII_MAX) || (c == CH_PERCENT)) begin
            return CH_SUBST;
        end
        return c;
    endfunction

endpackage

@@ rtl/rxk_text_mem.sv @@
// Command text store: synchronous RAM with a registered read and a copy of entry zero.
`timescale 1ns / 1ps

module rxk_text_mem
    import rxk_pkg::*;
#(
    parameter int KEY_TEXT_DEPTH = KEY_TEXT_DEPTH_DEF,
    parameter int AW             = $clog2(KEY_TEXT_DEPTH)
)
(
    input  logic          clk,
    input  mem_ctl_t      ctl,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    output logic [7:0]    entry0
);

    logic [7:0] mem [KEY_TEXT_DEPTH];
    logic [7:0] rd_data_reg;
    logic [7:0] entry0_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Entry zero stands in for a NUL read, so keep it at hand without a second port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && (wr_addr == '0))
        begin
            entry0_reg <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;
    assign entry0  = entry0_reg;

endmodule

@@ rtl/rxk_key_unit.sv @@
// Rolling key state, text index sequencing and the output register.
`timescale 1ns / 1ps

module rxk_key_unit
    import rxk_pkg::*;
#(
    parameter int KEY_TEXT_DEPTH = KEY_TEXT_DEPTH_DEF,
    parameter int AW             = $clog2(KEY_TEXT_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    challenge,
    input  item_ctl_t     ctl,
    input  logic [7:0]    seed,
    input  logic          start_odd,
    input  logic [7:0]    data_in,
    input  logic          final_req,
    input  logic [7:0]    rd_data,
    input  logic [7:0]    entry0,
    output logic [AW-1:0] rd_addr,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    data_out,
    output logic          last
);

    logic          s1_valid_reg, s1_valid_next;
    logic [AW-1:0] s1_idx_reg;
    logic [7:0]    s1_data_reg;
    logic          s1_last_reg;
    logic [7:0]    key_reg, key_next;
    logic          pos_reg, pos_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg;
    logic          out_last_reg;

    logic          s1_adv;
    logic          text_nul;
    logic [7:0]    text_ch;
    logic [7:0]    key_mix;
    logic [7:0]    key_new;
    logic [AW-1:0] idx_inc;
    logic [AW-1:0] idx_after;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // NUL at the index: fall back to entry zero, index resumes at one
    assign text_nul  = (rd_data == 8'd0);
    assign text_ch   = clean_char(text_nul ? entry0 : rd_data);
    assign key_mix   = pos_reg ? {text_ch[6:0], 1'b0} : text_ch;
    assign key_new   = key_reg ^ key_mix;
    assign idx_inc   = (s1_idx_reg == AW'(KEY_TEXT_DEPTH - 1)) ? '0 : s1_idx_reg + 1'b1;
    assign idx_after = text_nul ? AW'(1) : idx_inc;

    // Forward the index of the byte in flight to the next read
    assign rd_addr = s1_valid_reg ? idx_after : idx_reg;

    always_comb
    begin
        key_next = key_reg;
        pos_next = pos_reg;
        idx_next = idx_reg;
        priority if (ctl.start)
        begin
            key_next = challenge ^ seed;
            pos_next = start_odd;
            idx_next = '0;
        end
        else if (s1_adv)
        begin
            key_next = key_new;
            pos_next = ~pos_reg;
            idx_next = idx_after;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (ctl.data)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            pos_reg       <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            key_reg       <= key_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.data)
        begin
            s1_idx_reg  <= rd_addr;
            s1_data_reg <= data_in;
            s1_last_reg <= final_req;
        end
        if (s1_adv)
        begin
            out_data_reg <= s1_data_reg ^ key_new;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;
    assign last      = out_last_reg;

endmodule

@@ rtl/rolling_xor_key_stream_cipher.sv @@
// Top level of the rolling XOR key stream cipher: stream ports, register port, store and key unit.
//
//  channel   direction  handshake                 content
//  s_axis    in         tvalid / tready           load, start or data request
//  m_axis    out        tvalid / tready           encoded byte and end of message
//  apb       in         psel, penable, pready     challenge register
//
// One request per cycle unless m_axis stalls; a byte passes a stage-one and an output register.
// The rate is set by the single text RAM read port, whose next address is forwarded
// from the byte in flight. Reset clears key, index, parity, challenge and valid flags;
// the text RAM is not cleared. A stalled m_axis holds one result and one byte in flight,
// then drops s_axis_tready.
`timescale 1ns / 1ps

module rolling_xor_key_stream_cipher
    import rxk_pkg::*;
#(
    parameter int KEY_TEXT_DEPTH = KEY_TEXT_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // text_addr[9:0], text_char[17:10], seed[25:18], start_odd[26], data_in[34:27], zero[39:35]
    input  logic [39:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_out[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int  AW           = $clog2(KEY_TEXT_DEPTH);
    localparam logic REG_CHALLENGE = 1'b0;

    logic [7:0]    challenge_reg;
    logic          in_acc;
    cmd_t          cmd;
    logic [9:0]    text_addr;
    logic [7:0]    text_char;
    logic [7:0]    seed;
    logic          start_odd;
    logic [7:0]    data_in;
    mem_ctl_t      mem_ctl;
    item_ctl_t     item_ctl;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [7:0]    entry0;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CHALLENGE) ? {24'd0, challenge_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            challenge_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHALLENGE))
        begin
            challenge_reg <= pwdata[7:0];
        end
    end

    assign cmd       = cmd_t'(s_axis_tuser);
    assign text_addr = s_axis_tdata[9:0];
    assign text_char = s_axis_tdata[17:10];
    assign seed      = s_axis_tdata[25:18];
    assign start_odd = s_axis_tdata[26];
    assign data_in   = s_axis_tdata[34:27];

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Decode the request; loads beyond the store and the unused code are dropped
    always_comb
    begin
        mem_ctl  = '0;
        item_ctl = '0;
        if (in_acc)
        begin
            unique case (cmd)
                CMD_LOAD:
                begin
                    mem_ctl.wr_en = (32'(text_addr) < 32'(KEY_TEXT_DEPTH));
                end
                CMD_START:
                begin
                    item_ctl.start = 1'b1;
                end
                CMD_DATA:
                begin
                    item_ctl.data = 1'b1;
                    mem_ctl.rd_en = 1'b1;
                end
                default:
                begin
                    mem_ctl  = '0;
                    item_ctl = '0;
                end
            endcase
        end
    end

    rxk_text_mem #(
        .KEY_TEXT_DEPTH (KEY_TEXT_DEPTH),
        .AW             (AW)
    ) u_text_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (AW'(text_addr)),
        .wr_data (text_char),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .entry0  (entry0)
    );

    rxk_key_unit #(
        .KEY_TEXT_DEPTH (KEY_TEXT_DEPTH),
        .AW             (AW)
    ) u_key_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .challenge (challenge_reg),
        .ctl       (item_ctl),
        .seed      (seed),
        .start_odd (start_odd),
        .data_in   (data_in),
        .final_req (s_axis_tlast),
        .rd_data   (rd_data),
        .entry0    (entry0),
        .rd_addr   (rd_addr),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .data_out  (m_axis_tdata),
        .last      (m_axis_tlast)
    );

endmodule

@@ rtl/rxk_checker.sv @@
// Port-level checks of the rolling XOR cipher, bound to the top level.
`timescale 1ns / 1ps
`include "rolling_xor_key_stream_cipher_defines.svh"

module rxk_checker
    import rxk_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result holds its value
    `RXK_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // A result leaves only when taken
    `RXK_ASSERT(a_out_drop, clk, rst_n, $fell(m_axis_tvalid) |-> $past(m_axis_tready), "result dropped without handshake")

    // A fresh result follows a data request taken just before
    `RXK_ASSERT(a_out_cause, clk, rst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_DATA), 2), "result without a data request")

    // Requests stall only behind a stalled result
    `RXK_ASSERT(a_in_stall, clk, rst_n, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "request stalled with output free")

endmodule

bind rolling_xor_key_stream_cipher rxk_checker u_rxk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ dv/tb_top.sv @@
// Self-checking stream testbench for the rolling XOR key stream cipher.
`timescale 1ns / 1ps

module tb_top;
    import rxk_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int TEXT_DEPTH = 1024;
    localparam int GUARD_ADDR = 128;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_BEGIN = 20;
    localparam int HOLD_END = 420;
    localparam int LONG_MSG_BYTES = 300;
    localparam int PHASE_REQS = 165;
    localparam int MAX_REPORTS = 10;
    localparam longint TIMEOUT_NS = 64'd2_000_000;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] REG_CHALLENGE = 3'd0;

    typedef struct {
        logic [1:0] cmd;
        logic [9:0] addr;
        logic [7:0] tchar;
        logic [7:0] seed;
        logic       sodd;
        logic [7:0] din;
        logic       fin;
    } cipher_req_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } cipher_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted cipher state
    logic [7:0]  text_mem [TEXT_DEPTH];
    logic [7:0]  roll_key;
    logic [9:0]  text_pos;
    logic        pos_odd;
    logic [7:0]  challenge_val;

    cipher_req_t  pending_reqs[$];
    cipher_byte_t expected_bytes[$];
    cipher_req_t  cur_req;

    int queued_reqs = 0;
    int accepted_reqs = 0;
    int bytes_checked = 0;
    int fail_count = 0;
    int challenge_writes = 0;

    int burst_left = 1;
    int gap_left = 0;

    logic        hold_armed = 1'b0;
    int          hold_cnt = 0;
    logic        hold_off;

    rolling_xor_key_stream_cipher DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Apply one accepted request to the predicted state
    function automatic void advance_cipher_model(input cipher_req_t r);
        logic [7:0] c;
        logic [7:0] mix;
        cipher_byte_t res;
        case (r.cmd)
            CMD_LOAD: text_mem[r.addr] = r.tchar;
            CMD_START:
            begin
                roll_key = challenge_val ^ r.seed;
                text_pos = '0;
                pos_odd = r.sodd;
            end
            CMD_DATA:
            begin
                if (text_mem[text_pos] == 8'd0)
                    text_pos = '0;
                c = text_mem[text_pos];
                if (c > CH_ASCII_MAX || c == CH_PERCENT)
                    c = CH_SUBST;
                mix = pos_odd ? {c[6:0], 1'b0} : c;
                roll_key = roll_key ^ mix;
                text_pos = text_pos + 10'd1;   // 10 bits wrap at the end of the store
                pos_odd = ~pos_odd;
                res.data = r.din ^ roll_key;
                res.last = r.fin;
                expected_bytes.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input logic [8:0] exp_v,
                                            input logic [8:0] act_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch (%s): expected last=%0b data=%02h, got last=%0b data=%02h",
                     $realtime, what, exp_v[8], exp_v[7:0], act_v[8], act_v[7:0]);
    endfunction

    // Driver: bursts of requests separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_cipher_model(cur_req);
                accepted_reqs++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata <= {5'b0, cur_req.din, cur_req.sodd, cur_req.seed,
                                cur_req.tchar, cur_req.addr};
                    s_tuser <= cur_req.cmd;
                    s_tlast <= cur_req.fin;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once the long message begins
    assign hold_off = hold_armed && (hold_cnt >= HOLD_BEGIN) && (hold_cnt < HOLD_END);

    always @(posedge clk)
    begin
        if (hold_armed && hold_cnt < HOLD_END)
            hold_cnt <= hold_cnt + 1;
    end

    // Monitor: check each result and stall on a rotating pattern
    int rx_cycle = 0;
    always @(posedge clk)
    begin
        cipher_byte_t e;
        logic ready_bit;
        if (rst_n && m_tvalid && m_tready)
        begin
            bytes_checked++;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("no byte expected", 9'h0, {m_tlast, m_tdata});
            end
            else
            begin
                e = expected_bytes.pop_front();
                if (m_tdata !== e.data || m_tlast !== e.last)
                    report_mismatch("output byte", {e.last, e.data}, {m_tlast, m_tdata});
            end
        end
        rx_cycle++;
        case (rx_cycle[8:7])
            2'd0: ready_bit = 1'b1;
            2'd1: ready_bit = ($urandom_range(0, 3) != 0);
            2'd2: ready_bit = ($urandom_range(0, 2) == 0);
            default: ready_bit = rx_cycle[0];
        endcase
        m_tready <= rst_n && ready_bit && !hold_off;
    end

    function automatic cipher_req_t blank_req();
        cipher_req_t r;
        r.cmd = CMD_UNUSED;
        r.addr = 10'($urandom);
        r.tchar = 8'($urandom);
        r.seed = 8'($urandom);
        r.sodd = 1'($urandom);
        r.din = 8'($urandom);
        r.fin = 1'($urandom);
        return r;
    endfunction

    function automatic void push_req(input cipher_req_t r);
        pending_reqs.push_back(r);
        queued_reqs++;
    endfunction

    function automatic void push_load(input logic [9:0] addr, input logic [7:0] ch);
        cipher_req_t r;
        r = blank_req();
        r.cmd = CMD_LOAD;
        r.addr = addr;
        r.tchar = ch;
        push_req(r);
    endfunction

    function automatic void push_start(input logic [7:0] seed, input logic sodd);
        cipher_req_t r;
        r = blank_req();
        r.cmd = CMD_START;
        r.seed = seed;
        r.sodd = sodd;
        push_req(r);
    endfunction

    function automatic void push_data(input logic [7:0] din, input logic fin);
        cipher_req_t r;
        r = blank_req();
        r.cmd = CMD_DATA;
        r.din = din;
        r.fin = fin;
        push_req(r);
    endfunction

    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return CH_PERCENT;
            2: return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(1, 127));
        endcase
    endfunction

    // Leave the terminator at GUARD_ADDR in place so the index never leaves written text
    function automatic logic [9:0] rand_addr();
        if ($urandom_range(0, 4) == 0)
            return 10'($urandom_range(GUARD_ADDR + 1, TEXT_DEPTH - 1));
        return 10'($urandom_range(0, 31));
    endfunction

    task automatic wait_idle();
        while (accepted_reqs != queued_reqs || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the challenge, then read it back
    task automatic write_challenge(input logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_CHALLENGE;
        pwdata <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        challenge_val = value;
        challenge_writes++;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'd0, value})
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("[%0t] mismatch (challenge read): expected %08h, got %08h",
                         $realtime, {24'd0, value}, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_random_phase(input int target);
        int counted;
        int pick;
        int nload;
        int nbytes;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                nload = $urandom_range(0, 4);
                for (int i = 0; i < nload; i++)
                    push_load(rand_addr(), rand_char());
                push_start(8'($urandom), 1'($urandom));
                nbytes = $urandom_range(1, 24);
                for (int i = 0; i < nbytes; i++)
                    push_data(8'($urandom), i == nbytes - 1);
                counted += nload + 1 + nbytes;
            end
            else if (pick == 7)
            begin
                push_req(blank_req());   // unused code, dropped by the block
            end
            else if (pick == 8)
            begin
                push_data(8'($urandom), 1'($urandom));
                counted++;
            end
            else
            begin
                // message cut by a text load, no end marker
                push_start(8'($urandom), 1'($urandom));
                push_data(8'($urandom), 1'b0);
                push_load(rand_addr(), rand_char());
                push_data(8'($urandom), 1'b0);
                counted += 4;
            end
        end
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        cipher_req_t r;
        roll_key = '0;
        text_pos = '0;
        pos_odd = 1'b0;
        challenge_val = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Short text with percent, high characters and a terminator
        push_load(10'd0, 8'h41);
        push_load(10'd1, CH_PERCENT);
        push_load(10'd2, 8'hFF);
        push_load(10'd3, 8'h80);
        push_load(10'd4, 8'h7F);
        push_load(10'd5, 8'h00);
        push_load(10'd1023, 8'hFF);
        // bytes before any start use the reset key
        push_data(8'h00, 1'b0);
        push_data(8'hFF, 1'b1);
        r = blank_req();
        r.addr = '1;
        r.tchar = '1;
        r.seed = '1;
        r.sodd = 1'b1;
        r.din = '1;
        r.fin = 1'b1;
        push_req(r);
        push_start(8'hFF, 1'b1);
        for (int i = 0; i < 7; i++)
            push_data(8'($urandom), i == 6);
        push_start(8'h00, 1'b0);
        push_data(8'hFF, 1'b0);
        push_data(8'h00, 1'b1);
        // terminator at entry zero: the same entry is reused
        push_load(10'd0, 8'h00);
        push_start(8'h5A, 1'b1);
        for (int i = 0; i < 3; i++)
            push_data(8'($urandom), i == 2);
        wait_idle();

        write_challenge(8'hFF);
        // fill the head of the store without terminators, close it with one, then run past it
        for (int i = 0; i < GUARD_ADDR; i++)
            push_load(10'(i), 8'($urandom_range(1, 255)));
        push_load(10'(GUARD_ADDR), 8'h00);
        wait_idle();
        push_start(8'($urandom), 1'($urandom));
        for (int i = 0; i < LONG_MSG_BYTES; i++)
            push_data(8'($urandom), i == LONG_MSG_BYTES - 1);
        @(posedge clk);
        hold_armed <= 1'b1;
        wait_idle();

        write_challenge(8'h00);
        queue_random_phase(PHASE_REQS);
        wait_idle();
        write_challenge(8'($urandom));
        queue_random_phase(PHASE_REQS);
        wait_idle();
        write_challenge(8'hFF);
        queue_random_phase(PHASE_REQS);
        wait_idle();
        write_challenge(8'($urandom));
        queue_random_phase(PHASE_REQS);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests, %0d output bytes checked, %0d challenge settings,",
                 accepted_reqs, bytes_checked, challenge_writes);
        $display("text wraps at a terminator and a long output stall; %0d failures.",
                 fail_count);
        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rxk_pkg.sv
rtl/rxk_text_mem.sv
rtl/rxk_key_unit.sv
rtl/rolling_xor_key_stream_cipher.sv
rtl/rxk_checker.sv
dv/tb_top.sv
